// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files that check themselves.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ofps_pkg.sv -----
// Shared types and constants of the OLED frame push sequencer.
// No dependencies; used by every module of the block.
package ofps_pkg;

    // Input kinds
    typedef enum logic [2:0] {
        FN_FRAME    = 3'd0,
        FN_INVERT   = 3'd1,
        FN_CONTRAST = 3'd2,
        FN_ORIENT   = 3'd3,
        FN_SUSPEND  = 3'd4,
        FN_RESUME   = 3'd5
    } func_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PAGE_MODE     = 3'd0,
        CFG_SERIAL_BUS    = 3'd1,
        CFG_PANEL_WIDTH   = 3'd2,
        CFG_PANEL_HEIGHT  = 3'd3,
        CFG_COLUMN_OFFSET = 3'd4,
        CFG_FIRST_PAGE    = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        JOB_CMD    = 2'd0,
        JOB_FRAME  = 2'd1,
        JOB_REJECT = 2'd2
    } job_kind_t;

    typedef enum logic [1:0] {
        PRE_NONE  = 2'd0,
        PRE_HORIZ = 2'd1,
        PRE_PAGE  = 2'd2
    } pre_t;

    // Controller opcodes and bus constants
    localparam logic [7:0] CMD_PAGE_RANGE = 8'h22;
    localparam logic [7:0] CMD_COL_RANGE  = 8'h21;
    localparam logic [7:0] CMD_PAGE_START = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH   = 8'h10;
    localparam logic [7:0] CMD_INVERT_ON  = 8'hA7;
    localparam logic [7:0] CMD_INVERT_OFF = 8'hA6;
    localparam logic [7:0] CMD_CONTRAST   = 8'h81;
    localparam logic [7:0] CMD_SEG_REMAP  = 8'hA0;
    localparam logic [7:0] CMD_COM_INC    = 8'hC0;
    localparam logic [7:0] CMD_COM_DEC    = 8'hC8;
    localparam logic [7:0] CMD_DISP_OFF   = 8'hAE;
    localparam logic [7:0] CMD_DISP_ON    = 8'hAF;
    localparam logic [7:0] PREFIX_CMD     = 8'h00;
    localparam logic [7:0] PREFIX_DATA    = 8'h40;
    localparam logic [7:0] NIBBLE_MASK    = 8'h0F;
    localparam logic [7:0] NARROW_SHIFT   = 8'h20;
    localparam logic [8:0] NARROW_WIDTH   = 9'd64;

    localparam int PAGE_W      = 3;  // page position, up to 8 pages
    localparam int WIDTH_W     = 9;  // effective width, up to 256 columns
    localparam int NPAGE_W     = 4;  // effective page count, 1..8
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int STEP_W      = 3;  // command index within a job, up to 6

    typedef struct packed {
        logic       page_mode;
        logic       serial_bus;
        logic [7:0] panel_width;
        logic [6:0] panel_height;
        logic [7:0] column_offset;
        logic [7:0] first_page;
    } cfg_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [NPAGE_W-1:0] pages;
        logic [7:0]         col_start;
        logic [7:0]         col_end;
        logic [7:0]         last_page;
    } geom_t;

    // One classified request, handed from the front to the back
    typedef struct packed {
        job_kind_t         kind;
        pre_t              pre;
        logic [PAGE_W-1:0] page_idx;
        logic              open;    // data transaction opens with this byte
        logic              close;   // data byte closes its transaction
        logic              two;     // command request sends two commands
        logic [7:0]        byte0;   // frame byte or first command
        logic [7:0]        byte1;   // second command
    } job_t;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       is_data;
        logic       is_prefix;
        logic       txn_end;
        logic       last;
        logic       status;
    } out_t;

endpackage

// ----- hw/rtl/ofps_queue.sv -----
// Short job queue between the front and the back of the sequencer.
// Depends on ofps_pkg (job_t, depth constants).
module ofps_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ofps_pkg::job_t  push_job,
    input  logic            pop,
    output ofps_pkg::job_t  head,
    output logic            not_empty,
    output logic            full
);

    ofps_pkg::job_t                  mem_reg [ofps_pkg::QUEUE_DEPTH];
    logic [ofps_pkg::QPTR_W-1:0]     wr_reg;
    logic [ofps_pkg::QPTR_W-1:0]     rd_reg;
    logic [ofps_pkg::QPTR_W:0]       cnt_reg;
    logic [ofps_pkg::QPTR_W:0]       cnt_next;

    assign head      = mem_reg[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == (ofps_pkg::QPTR_W + 1)'(ofps_pkg::QUEUE_DEPTH));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/ofps_front.sv -----
// Front end: accepts requests, tracks frame position, builds jobs for the queue.
// Depends on ofps_pkg (func_t, job_t, cfg_t, geom_t).
module ofps_front #(
    parameter int MAX_COLUMNS = 128,
    parameter int CHUNK_BYTES = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,   // [7:0] value
    input  logic [2:0]      s_axis_tuser,   // [2:0] func
    input  logic            restart,
    input  ofps_pkg::cfg_t  cfg,
    input  ofps_pkg::geom_t geom,
    input  logic            q_full,
    output logic            push,
    output ofps_pkg::job_t  job
);

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int CHK_W = $clog2(CHUNK_BYTES + 1);

    logic [COL_W-1:0]            col_reg, col_next;
    logic [ofps_pkg::PAGE_W-1:0] pg_reg, pg_next;
    logic [CHK_W-1:0]            chk_reg, chk_next;
    logic                        open_reg, open_next;
    logic                        susp_reg, susp_next;

    logic [ofps_pkg::WIDTH_W-1:0] col_inc;
    logic [ofps_pkg::PAGE_W:0]    pg_inc;
    logic [CHK_W-1:0]             chk_inc;
    logic                         close;
    logic                         want;
    logic                         accept;
    logic [7:0]                   value;

    assign value         = s_axis_tdata;
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign push          = accept && want;

    always_comb
    begin
        col_inc = ofps_pkg::WIDTH_W'(col_reg) + ofps_pkg::WIDTH_W'(1);
        pg_inc  = {1'b0, pg_reg} + (ofps_pkg::PAGE_W + 1)'(1);
        chk_inc = (open_reg ? chk_reg : '0) + CHK_W'(1);
        close   = 1'b0;
        want    = 1'b0;

        col_next  = col_reg;
        pg_next   = pg_reg;
        chk_next  = chk_reg;
        open_next = open_reg;
        susp_next = susp_reg;

        job          = '0;
        job.kind     = ofps_pkg::JOB_CMD;
        job.pre      = ofps_pkg::PRE_NONE;
        job.page_idx = pg_reg;
        job.open     = !open_reg;
        job.byte0    = value;
        job.byte1    = value;

        case (ofps_pkg::func_t'(s_axis_tuser))
            ofps_pkg::FN_FRAME:
            begin
                want = 1'b1;
                if (susp_reg)
                begin
                    job.kind = ofps_pkg::JOB_REJECT;
                end
                else
                begin
                    job.kind = ofps_pkg::JOB_FRAME;
                    if (col_reg == '0)
                    begin
                        if (cfg.page_mode)
                        begin
                            job.pre = ofps_pkg::PRE_PAGE;
                        end
                        else if (pg_reg == '0)
                        begin
                            job.pre = ofps_pkg::PRE_HORIZ;
                        end
                    end
                    close     = (chk_inc >= CHK_W'(CHUNK_BYTES));
                    col_next  = col_inc[COL_W-1:0];
                    open_next = 1'b1;
                    chk_next  = chk_inc;
                    if (col_inc >= geom.width)
                    begin
                        // end of a page row
                        col_next = '0;
                        if (cfg.page_mode)
                        begin
                            close = 1'b1;
                        end
                        if (pg_inc >= geom.pages)
                        begin
                            pg_next = '0;
                            close   = 1'b1;
                        end
                        else
                        begin
                            pg_next = pg_inc[ofps_pkg::PAGE_W-1:0];
                        end
                    end
                    if (close)
                    begin
                        open_next = 1'b0;
                        chk_next  = '0;
                    end
                    job.close = close;
                end
            end
            ofps_pkg::FN_INVERT:
            begin
                want      = 1'b1;
                open_next = 1'b0;
                chk_next  = '0;
                job.byte0 = value[0] ? ofps_pkg::CMD_INVERT_ON : ofps_pkg::CMD_INVERT_OFF;
            end
            ofps_pkg::FN_CONTRAST:
            begin
                want      = 1'b1;
                open_next = 1'b0;
                chk_next  = '0;
                job.two   = 1'b1;
                job.byte0 = ofps_pkg::CMD_CONTRAST;
                job.byte1 = value;
            end
            ofps_pkg::FN_ORIENT:
            begin
                want      = 1'b1;
                open_next = 1'b0;
                chk_next  = '0;
                job.two   = 1'b1;
                job.byte0 = ofps_pkg::CMD_SEG_REMAP | {7'd0, !value[0]};
                job.byte1 = value[0] ? ofps_pkg::CMD_COM_INC : ofps_pkg::CMD_COM_DEC;
            end
            ofps_pkg::FN_SUSPEND:
            begin
                want      = 1'b1;
                open_next = 1'b0;
                chk_next  = '0;
                susp_next = 1'b1;
                job.byte0 = ofps_pkg::CMD_DISP_OFF;
            end
            ofps_pkg::FN_RESUME:
            begin
                want      = 1'b1;
                open_next = 1'b0;
                chk_next  = '0;
                susp_next = 1'b0;
                job.byte0 = ofps_pkg::CMD_DISP_ON;
            end
            default:
            begin
                want = 1'b0;  // undefined kinds are dropped
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            pg_reg   <= '0;
            chk_reg  <= '0;
            open_reg <= 1'b0;
            susp_reg <= 1'b0;
        end
        else if (restart)
        begin
            col_reg  <= '0;
            pg_reg   <= '0;
            chk_reg  <= '0;
            open_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            pg_reg   <= pg_next;
            chk_reg  <= chk_next;
            open_reg <= open_next;
            susp_reg <= susp_next;
        end
    end

endmodule

// ----- hw/rtl/ofps_back.sv -----
// Back end: expands queued jobs into registered bus bytes, one per unstalled cycle.
// Depends on ofps_pkg (job_t, cfg_t, geom_t, out_t, opcodes).
module ofps_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ofps_pkg::cfg_t  cfg,
    input  ofps_pkg::geom_t geom,
    input  ofps_pkg::job_t  job,
    input  logic            job_valid,
    output logic            pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [15:0]     m_axis_tdata,   // [7:0] bus_byte, [8] is_data,
                                            // [9] is_prefix, [10] txn_end
    output logic            m_axis_tlast,
    output logic            m_axis_tuser    // [0] status
);

    logic [ofps_pkg::STEP_W-1:0] idx_reg, idx_next;
    logic                        sub_reg, sub_next;
    logic                        out_valid_reg;
    ofps_pkg::out_t              out_reg;

    logic [ofps_pkg::STEP_W-1:0] ncmd;
    logic [7:0]                  cmd_byte;
    logic [ofps_pkg::PAGE_W-1:0] page_num;
    ofps_pkg::out_t              step_out;
    logic                        done;
    logic                        advance;

    assign advance  = job_valid && (!out_valid_reg || m_axis_tready);
    assign pop      = advance && done;
    assign page_num = cfg.first_page[ofps_pkg::PAGE_W-1:0] + job.page_idx;

    // Command list of the job at the head of the queue
    always_comb
    begin
        ncmd     = '0;
        cmd_byte = job.byte0;
        case (job.kind)
            ofps_pkg::JOB_CMD:
            begin
                ncmd     = job.two ? ofps_pkg::STEP_W'(2) : ofps_pkg::STEP_W'(1);
                cmd_byte = (idx_reg == '0) ? job.byte0 : job.byte1;
            end
            ofps_pkg::JOB_FRAME:
            begin
                case (job.pre)
                    ofps_pkg::PRE_HORIZ:
                    begin
                        ncmd = ofps_pkg::STEP_W'(6);
                        case (idx_reg)
                            3'd0:    cmd_byte = ofps_pkg::CMD_PAGE_RANGE;
                            3'd1:    cmd_byte = cfg.first_page;
                            3'd2:    cmd_byte = geom.last_page;
                            3'd3:    cmd_byte = ofps_pkg::CMD_COL_RANGE;
                            3'd4:    cmd_byte = geom.col_start;
                            default: cmd_byte = geom.col_end;
                        endcase
                    end
                    ofps_pkg::PRE_PAGE:
                    begin
                        ncmd = ofps_pkg::STEP_W'(3);
                        case (idx_reg)
                            3'd0:    cmd_byte = cfg.column_offset & ofps_pkg::NIBBLE_MASK;
                            3'd1:    cmd_byte = ofps_pkg::CMD_COL_HIGH
                                                | {4'd0, cfg.column_offset[7:4]};
                            default: cmd_byte = ofps_pkg::CMD_PAGE_START
                                                | {5'd0, page_num};
                        endcase
                    end
                    default: ncmd = '0;
                endcase
            end
            default: ncmd = '0;
        endcase
    end

    // One bus byte per step
    always_comb
    begin
        step_out = '0;
        done     = 1'b0;
        idx_next = idx_reg;
        sub_next = sub_reg;
        if (job.kind == ofps_pkg::JOB_REJECT)
        begin
            step_out.status = 1'b1;
            step_out.last   = 1'b1;
            done            = 1'b1;
        end
        else if (idx_reg < ncmd)
        begin
            if (!cfg.serial_bus && !sub_reg)
            begin
                step_out.bus_byte  = ofps_pkg::PREFIX_CMD;
                step_out.is_prefix = 1'b1;
                sub_next           = 1'b1;
            end
            else
            begin
                step_out.bus_byte = cmd_byte;
                step_out.txn_end  = 1'b1;
                sub_next          = 1'b0;
                idx_next          = idx_reg + 1'b1;
                if (job.kind == ofps_pkg::JOB_CMD && idx_reg == ncmd - 1'b1)
                begin
                    step_out.last = 1'b1;
                    done          = 1'b1;
                end
            end
        end
        else
        begin
            if (!cfg.serial_bus && job.open && !sub_reg)
            begin
                step_out.bus_byte  = ofps_pkg::PREFIX_DATA;
                step_out.is_data   = 1'b1;
                step_out.is_prefix = 1'b1;
                sub_next           = 1'b1;
            end
            else
            begin
                step_out.bus_byte = job.byte0;
                step_out.is_data  = 1'b1;
                step_out.txn_end  = job.close;
                step_out.last     = 1'b1;
                done              = 1'b1;
            end
        end
        if (done)
        begin
            idx_next = '0;
            sub_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= step_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            sub_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                idx_reg       <= idx_next;
                sub_reg       <= sub_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.txn_end, out_reg.is_prefix,
                            out_reg.is_data, out_reg.bus_byte};
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tuser  = out_reg.status;

endmodule

// ----- hw/rtl/oled_frame_push_sequencer.sv -----
// Top level of the OLED frame push sequencer: config registers, geometry, front, queue, back.
// Depends on ofps_pkg, ofps_front, ofps_queue, ofps_back and assert_macros.svh.
//
//   channel   dir  handshake               payload
//   s_axis    in   s_axis_tvalid/tready    tdata[7:0] value, tuser[2:0] func
//   m_axis    out  m_axis_tvalid/tready    tdata bus byte + flags, tlast, tuser status
//   cfg       in   cfg_valid/cfg_ready     cfg_index[2:0], cfg_data[7:0]
//
// A request is taken whenever the job queue has room; the front
// classifies it and updates the frame position in the cycle it is taken.
// The back emits one bus byte per cycle while m_axis_tready is high, so the
// output port sets the sustained rate and the 4-entry queue absorbs bursts.
// A frame byte in an open transaction goes out alone, a transaction start
// adds a data prefix, a frame start first sends its addressing commands and
// a command request one or two commands; only a non-serial bus gets prefixes.
// Reset (rst_n low, async) clears position, suspend flag, queue and
// restores the register defaults. No clearing pass is needed.
`include "assert_macros.svh"

module oled_frame_push_sequencer #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_PAGES   = 8,
    parameter int CHUNK_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] value
    input  logic [2:0]  s_axis_tuser,   // [2:0] func
    // bus byte stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] bus_byte, [8] is_data,
                                        // [9] is_prefix, [10] txn_end, rest zero
    output logic        m_axis_tlast,   // last byte of a request
    output logic        m_axis_tuser,   // [0] status (rejected frame byte)
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [ofps_pkg::WIDTH_W-1:0] MaxCols  = ofps_pkg::WIDTH_W'(MAX_COLUMNS);
    localparam logic [ofps_pkg::NPAGE_W:0]   MaxPages = (ofps_pkg::NPAGE_W + 1)'(MAX_PAGES);

    ofps_pkg::cfg_t  cfg_reg;
    ofps_pkg::geom_t geom;
    ofps_pkg::job_t  push_job;
    ofps_pkg::job_t  head_job;
    logic            restart;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_not_empty;

    logic [ofps_pkg::WIDTH_W-1:0] width_eff;
    logic [ofps_pkg::NPAGE_W:0]   pages_raw;
    logic [ofps_pkg::NPAGE_W:0]   pages_eff;
    logic [7:0]                   col_start;

    // Register port never stalls; the user must write only while the block is idle (not enforced here).
    assign cfg_ready = 1'b1;

    // Any write to a defined register restarts the frame.
    always_comb
    begin
        unique case (ofps_pkg::cfg_idx_t'(cfg_index))
            ofps_pkg::CFG_PAGE_MODE, ofps_pkg::CFG_SERIAL_BUS,
            ofps_pkg::CFG_PANEL_WIDTH, ofps_pkg::CFG_PANEL_HEIGHT,
            ofps_pkg::CFG_COLUMN_OFFSET, ofps_pkg::CFG_FIRST_PAGE:
                restart = cfg_valid;
            default:
                restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.page_mode     <= 1'b0;
            cfg_reg.serial_bus    <= 1'b0;
            cfg_reg.panel_width   <= 8'd128;
            cfg_reg.panel_height  <= 7'd64;
            cfg_reg.column_offset <= 8'd0;
            cfg_reg.first_page    <= 8'd0;
        end
        else if (cfg_valid)
        begin
            case (ofps_pkg::cfg_idx_t'(cfg_index))
                ofps_pkg::CFG_PAGE_MODE:     cfg_reg.page_mode     <= cfg_data[0];
                ofps_pkg::CFG_SERIAL_BUS:    cfg_reg.serial_bus    <= cfg_data[0];
                ofps_pkg::CFG_PANEL_WIDTH:   cfg_reg.panel_width   <= cfg_data;
                ofps_pkg::CFG_PANEL_HEIGHT:  cfg_reg.panel_height  <= cfg_data[6:0];
                ofps_pkg::CFG_COLUMN_OFFSET: cfg_reg.column_offset <= cfg_data;
                ofps_pkg::CFG_FIRST_PAGE:    cfg_reg.first_page    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective geometry; both halves read it live, so the user must change it only while idle (not enforced here).
    always_comb
    begin
        width_eff = {1'b0, cfg_reg.panel_width};
        if (width_eff == '0)
        begin
            width_eff = ofps_pkg::WIDTH_W'(1);
        end
        if (width_eff > MaxCols)
        begin
            width_eff = MaxCols;
        end

        pages_raw = 5'(({1'b0, cfg_reg.panel_height} + 8'd7) >> 3);
        pages_eff = pages_raw;
        if (pages_eff == '0)
        begin
            pages_eff = (ofps_pkg::NPAGE_W + 1)'(1);
        end
        if (pages_eff > MaxPages)
        begin
            pages_eff = MaxPages;
        end

        // 64-column glass sits in the middle of the 128-column controller
        col_start = cfg_reg.column_offset
                    + ((width_eff == ofps_pkg::NARROW_WIDTH) ? ofps_pkg::NARROW_SHIFT : 8'd0);

        geom.width     = width_eff;
        geom.pages     = pages_eff[ofps_pkg::NPAGE_W-1:0];
        geom.col_start = col_start;
        geom.col_end   = col_start + width_eff[7:0] - 8'd1;
        geom.last_page = cfg_reg.first_page + {4'd0, pages_eff[ofps_pkg::NPAGE_W-1:0]} - 8'd1;
    end

    ofps_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .restart       (restart),
        .cfg           (cfg_reg),
        .geom          (geom),
        .q_full        (q_full),
        .push          (push),
        .job           (push_job)
    );

    ofps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head      (head_job),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    ofps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .geom          (geom),
        .job           (head_job),
        .job_valid     (q_not_empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // A rejected frame byte is always a single, final result.
    `ASSERT_IMPLIES(a_reject_is_last, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "rejected result not marked last")

    // A control prefix never closes a transaction or a request.
    `ASSERT_IMPLIES(a_prefix_not_end, clk, rst_n, m_axis_tvalid && m_axis_tdata[9], !m_axis_tdata[10] && !m_axis_tlast, "prefix byte marked as an end")

    // Once a prefix is taken, its payload byte follows in the very next cycle.
    `ASSERT_NEXT(a_prefix_followed, clk, rst_n, m_axis_tvalid && m_axis_tready && m_axis_tdata[9], m_axis_tvalid && !m_axis_tdata[9], "prefix not followed by its byte")

endmodule
